### rtl/core/bdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

    localparam int DATA_W        = 32;
    localparam int CMD_W         = 3;
    localparam int CAP_W         = 5;
    localparam int COUNT_W       = 5;
    localparam int DEFAULT_DEPTH = 16;

    localparam logic [CAP_W-1:0]  CAP_RESET   = 5'd16;
    localparam logic [DATA_W-1:0] EMPTY_VALUE = 32'hFFFF_FFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_QUERY      = 3'd4
    } cmd_t;

    typedef struct packed {
        logic               accepted;
        logic               is_empty;
        logic               is_full;
        logic [COUNT_W-1:0] entry_count;
    } status_t;

endpackage

`default_nettype wire

### rtl/core/bdq_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bdq_req_if;
    import bdq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

`default_nettype wire

### rtl/core/bdq_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bdq_rsp_if;
    import bdq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     accepted;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
    logic [COUNT_W-1:0]       entry_count;

    modport source (output valid, output accepted, output front_value, output rear_value,
                    output is_empty, output is_full, output entry_count, input ready);
    modport sink   (input valid, input accepted, input front_value, input rear_value,
                    input is_empty, input is_full, input entry_count, output ready);
endinterface

`default_nettype wire

### rtl/core/bdq_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bdq_cfg_if;
    import bdq_pkg::*;

    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/bdq_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Ring storage: one write port, two registered read ports, write-first on a
// same-address read so a push is seen by the read issued in the same cycle.
module bdq_store #(
    parameter int DEPTH = bdq_pkg::DEFAULT_DEPTH,
    parameter int PTR_W = 4
) (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [PTR_W-1:0]            wr_addr,
    input  wire logic [bdq_pkg::DATA_W-1:0]  wr_data,
    input  wire logic [PTR_W-1:0]            rd_addr_front,
    input  wire logic [PTR_W-1:0]            rd_addr_rear,
    output      logic [bdq_pkg::DATA_W-1:0]  rd_front,
    output      logic [bdq_pkg::DATA_W-1:0]  rd_rear
);
    import bdq_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_front <= (wr_en && wr_addr == rd_addr_front) ? wr_data : mem[rd_addr_front];
        rd_rear  <= (wr_en && wr_addr == rd_addr_rear)  ? wr_data : mem[rd_addr_rear];
    end

endmodule

`default_nettype wire

### rtl/core/bdq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bdq_ctrl #(
    parameter int DEPTH = bdq_pkg::DEFAULT_DEPTH,
    parameter int PTR_W = 4,
    parameter int CNT_W = 5
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    bdq_req_if.sink                          req,
    bdq_rsp_if.source                        rsp,
    bdq_cfg_if.sink                          cfg,
    output      logic                        wr_en,
    output      logic [PTR_W-1:0]            wr_addr,
    output      logic [bdq_pkg::DATA_W-1:0]  wr_data,
    output      logic [PTR_W-1:0]            rd_addr_front,
    output      logic [PTR_W-1:0]            rd_addr_rear,
    input  wire logic [bdq_pkg::DATA_W-1:0]  rd_front,
    input  wire logic [bdq_pkg::DATA_W-1:0]  rd_rear
);
    import bdq_pkg::*;

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOAD = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CAP_W-1:0]  cap_reg;
    logic [PTR_W-1:0]  front_reg, front_next;
    logic [PTR_W-1:0]  rear_reg, rear_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    status_t           stat_reg, stat_next;
    logic              out_valid_reg;
    status_t           out_stat_reg;
    logic [DATA_W-1:0] out_front_reg, out_rear_reg;

    logic              take;
    logic              full_now, full_after, ok;
    logic [31:0]       limit, occ32_next;
    logic [PTR_W-1:0]  front_prev, rear_succ;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
        return (p == '0) ? LAST_SLOT : p - PTR_W'(1);
    endfunction

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign take      = req.valid && req.ready;

    assign limit      = (32'(cap_reg) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(cap_reg);
    assign full_now   = 32'(occ_reg) >= limit;
    assign front_prev = ring_prev(front_reg);
    assign rear_succ  = ring_next(rear_reg);

    always_comb
    begin
        front_next = front_reg;
        rear_next  = rear_reg;
        occ_next   = occ_reg;
        ok         = 1'b1;
        wr_en      = 1'b0;
        wr_addr    = front_reg;
        unique case (cmd_t'(req.command))
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (full_now)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    wr_en    = take;
                    occ_next = occ_reg + CNT_W'(1);
                    if (occ_reg == '0)
                    begin
                        rear_next = front_reg;
                        wr_addr   = front_reg;
                    end
                    else if (cmd_t'(req.command) == CMD_PUSH_FRONT)
                    begin
                        front_next = front_prev;
                        wr_addr    = front_prev;
                    end
                    else
                    begin
                        rear_next = rear_succ;
                        wr_addr   = rear_succ;
                    end
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (occ_reg == '0)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    occ_next = occ_reg - CNT_W'(1);
                    // last entry out: pointers stay put
                    if (occ_reg != CNT_W'(1))
                    begin
                        if (cmd_t'(req.command) == CMD_POP_FRONT)
                        begin
                            front_next = ring_next(front_reg);
                        end
                        else
                        begin
                            rear_next = ring_prev(rear_reg);
                        end
                    end
                end
            end
            default:
            begin
                ok = 1'b1;
            end
        endcase
    end

    assign wr_data       = req.value;
    assign rd_addr_front = front_next;
    assign rd_addr_rear  = rear_next;

    assign occ32_next = 32'(occ_next);
    assign full_after = occ32_next >= limit;

    always_comb
    begin
        stat_next.accepted    = ok;
        stat_next.is_empty    = (occ_next == '0);
        stat_next.is_full     = full_after;
        stat_next.entry_count = occ32_next[COUNT_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (take) state_next = ST_LOAD;
            ST_LOAD: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            front_reg     <= '0;
            rear_reg      <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                cap_reg <= cfg.data;
            end
            if (take)
            begin
                front_reg <= front_next;
                rear_reg  <= rear_next;
                occ_reg   <= occ_next;
            end
            if (state_reg == ST_LOAD)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // status is registered at accept; in ST_LOAD it moves to the output with the store read data
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stat_reg <= stat_next;
        end
        if (state_reg == ST_LOAD)
        begin
            out_stat_reg  <= stat_reg;
            out_front_reg <= stat_reg.is_empty ? EMPTY_VALUE : rd_front;
            out_rear_reg  <= stat_reg.is_empty ? EMPTY_VALUE : rd_rear;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.accepted    = out_stat_reg.accepted;
    assign rsp.is_empty    = out_stat_reg.is_empty;
    assign rsp.is_full     = out_stat_reg.is_full;
    assign rsp.entry_count = out_stat_reg.entry_count;
    assign rsp.front_value = out_front_reg;
    assign rsp.rear_value  = out_rear_reg;

endmodule

`default_nettype wire

### rtl/core/bounded_double_ended_queue.sv
// Bounded double-ended queue on a ring of DEPTH 32-bit entries.
// req channel: one operation per beat (push front, push back, pop front,
//   pop back, query; unused codes act as a query) with the value to push.
// rsp channel: one beat per operation giving whether it was accepted, the
//   front and rear entries (all ones when empty), empty, full and count.
// cfg channel: writes the capacity (0..31, clipped to DEPTH; zero refuses
//   every push); always ready, write only while no operation is in flight.
// Sequence: pointer update, store write and store read happen at the request
//   beat; the output register is then loaded from the read data in ST_LOAD,
//   and rsp.valid rises as it is loaded.
// Flow: no new request is taken while ST_LOAD is loading the output register.
// Stall: the result waits in the output register; the next request is taken
//   in the cycle that result is taken, not before.
// Reset: pointers and count clear, capacity returns to 16, queue is empty.
//   The entry store is not cleared; only live slots ever reach rsp.
`timescale 1ns / 1ps
`default_nettype none

module bounded_double_ended_queue #(
    parameter int DEPTH = bdq_pkg::DEFAULT_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bdq_req_if.sink   req,
    bdq_rsp_if.source rsp,
    bdq_cfg_if.sink   cfg
);
    import bdq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [PTR_W-1:0]  rd_addr_front, rd_addr_rear;
    logic [DATA_W-1:0] rd_front, rd_rear;

    bdq_ctrl #(
        .DEPTH (DEPTH),
        .PTR_W (PTR_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .cfg           (cfg),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_addr_front (rd_addr_front),
        .rd_addr_rear  (rd_addr_rear),
        .rd_front      (rd_front),
        .rd_rear       (rd_rear)
    );

    bdq_store #(
        .DEPTH (DEPTH),
        .PTR_W (PTR_W)
    ) u_store (
        .clk           (clk),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_addr_front (rd_addr_front),
        .rd_addr_rear  (rd_addr_rear),
        .rd_front      (rd_front),
        .rd_rear       (rd_rear)
    );

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bdq_pkg::*;

    localparam int RING_DEPTH     = DEFAULT_DEPTH;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 19;

    // codes outside the enum; the block treats them as a query
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_MID   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    typedef struct {
        bit                       is_cap;
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] value;
        bit                       bursty;
    } stim_t;

    typedef struct {
        logic               accepted;
        logic [DATA_W-1:0]  front_value;
        logic [DATA_W-1:0]  rear_value;
        logic               is_empty;
        logic               is_full;
        logic [COUNT_W-1:0] entry_count;
    } outcome_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                     req_valid_q = 1'b0;
    logic [CMD_W-1:0]         req_cmd_q   = CMD_QUERY;
    logic signed [DATA_W-1:0] req_value_q = '0;
    logic                     cfg_valid_q = 1'b0;
    logic [CAP_W-1:0]         cfg_data_q  = CAP_RESET;
    logic                     rsp_ready_q = 1'b0;
    logic                     stall_on    = 1'b0;

    bdq_req_if req_bus ();
    bdq_rsp_if rsp_bus ();
    bdq_cfg_if cfg_bus ();

    assign req_bus.valid   = req_valid_q;
    assign req_bus.command = req_cmd_q;
    assign req_bus.value   = req_value_q;
    assign cfg_bus.valid   = cfg_valid_q;
    assign cfg_bus.data    = cfg_data_q;
    assign rsp_bus.ready   = rsp_ready_q;

    bounded_double_ended_queue #(.DEPTH(RING_DEPTH)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- deque mirror
    logic [DATA_W-1:0] ring [RING_DEPTH];
    int unsigned       head_slot = 0;
    int unsigned       tail_slot = 0;
    int unsigned       held      = 0;
    logic [CAP_W-1:0]  cap_model = CAP_RESET;

    stim_t    pending [$];
    outcome_t expected [$];

    int mismatches  = 0;
    int results     = 0;
    int refusals    = 0;
    int full_seen   = 0;
    int empty_seen  = 0;
    int cap_writes  = 0;

    function automatic outcome_t deque_step(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] val);
        outcome_t    o;
        int unsigned lim;
        logic        ok;
        lim = (cap_model > RING_DEPTH) ? RING_DEPTH : cap_model;
        ok  = 1'b1;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (held >= lim)
                    ok = 1'b0;
                else
                begin
                    if (held == 0)
                        tail_slot = head_slot;
                    else if (cmd == CMD_PUSH_FRONT)
                        head_slot = (head_slot == 0) ? RING_DEPTH - 1 : head_slot - 1;
                    else
                        tail_slot = (tail_slot == RING_DEPTH - 1) ? 0 : tail_slot + 1;
                    ring[(cmd == CMD_PUSH_FRONT) ? head_slot : tail_slot] = val;
                    held++;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (held == 0)
                    ok = 1'b0;
                else
                begin
                    // last entry out: pointers are left where they are
                    if (held > 1)
                    begin
                        if (cmd == CMD_POP_FRONT)
                            head_slot = (head_slot == RING_DEPTH - 1) ? 0 : head_slot + 1;
                        else
                            tail_slot = (tail_slot == 0) ? RING_DEPTH - 1 : tail_slot - 1;
                    end
                    held--;
                end
            end
            default: ;
        endcase
        o.accepted    = ok;
        o.is_empty    = (held == 0);
        o.front_value = o.is_empty ? EMPTY_VALUE : ring[head_slot];
        o.rear_value  = o.is_empty ? EMPTY_VALUE : ring[tail_slot];
        o.is_full     = (held >= lim);
        o.entry_count = COUNT_W'(held);
        return o;
    endfunction

    function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
        end
    endfunction

    // ---------------------------------------------------------------- monitor
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                cap_model = cfg_bus.data;
                cap_writes++;
            end
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (expected.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: result beat with nothing outstanding", $time);
                end
                else
                begin
                    want = expected.pop_front();
                    check_field("accepted", DATA_W'(want.accepted),
                                DATA_W'(rsp_bus.accepted));
                    check_field("front_value", want.front_value, rsp_bus.front_value);
                    check_field("rear_value",  want.rear_value,  rsp_bus.rear_value);
                    check_field("is_empty", DATA_W'(want.is_empty),
                                DATA_W'(rsp_bus.is_empty));
                    check_field("is_full", DATA_W'(want.is_full),
                                DATA_W'(rsp_bus.is_full));
                    check_field("entry_count", DATA_W'(want.entry_count),
                                DATA_W'(rsp_bus.entry_count));
                    results++;
                    refusals   += !want.accepted;
                    full_seen  += want.is_full;
                    empty_seen += want.is_empty;
                end
            end
            // a result and a new request may share an edge; compare first
            if (req_bus.valid && req_bus.ready)
                expected.push_back(deque_step(req_bus.command, req_bus.value));
        end
    end

    // ---------------------------------------------------------------- driver
    int in_flight = 0;
    int settle    = 0;
    int gap_left  = 0;

    always @(posedge clk)
    begin
        stim_t                    head;
        logic                     nv;
        logic                     cv;
        logic [CMD_W-1:0]         nc;
        logic signed [DATA_W-1:0] nd;
        logic [CAP_W-1:0]         cd;
        nv = req_valid_q;
        nc = req_cmd_q;
        nd = req_value_q;
        cv = cfg_valid_q;
        cd = cfg_data_q;
        if (!rst_n)
        begin
            nv        = 1'b0;
            cv        = 1'b0;
            in_flight = 0;
            settle    = 0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                in_flight++;
                nv = 1'b0;
            end
            if (rsp_bus.valid && rsp_bus.ready)
                in_flight--;
            if (cfg_bus.valid && cfg_bus.ready)
                cv = 1'b0;
            if (in_flight != 0)
                settle = 0;
            else if (settle < SETTLE_CYCLES)
                settle++;

            if (!nv && !cv)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending.size() != 0)
                begin
                    // capacity only changes once the block has drained
                    if (!pending[0].is_cap)
                    begin
                        head     = pending.pop_front();
                        nv       = 1'b1;
                        nc       = head.command;
                        nd       = head.value;
                        stall_on <= head.bursty;
                        if (head.bursty && $urandom_range(0, 3) == 0)
                            gap_left = $urandom_range(1, 3);
                    end
                    else if (settle >= SETTLE_CYCLES)
                    begin
                        head = pending.pop_front();
                        cv   = 1'b1;
                        cd   = head.value[CAP_W-1:0];
                    end
                end
            end
        end
        req_valid_q <= nv;
        req_cmd_q   <= nc;
        req_value_q <= nd;
        cfg_valid_q <= cv;
        cfg_data_q  <= cd;
    end

    // result side back-pressure in random bursts while stall_on is set
    int stall_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready_q <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready_q <= 1'b0;
        end
        else if (stall_on && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            rsp_ready_q <= 1'b0;
        end
        else
            rsp_ready_q <= 1'b1;
    end

    // ---------------------------------------------------------------- watchdog
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------------------------------------------------------- stimulus
    bit fill_bursty = 1'b1;

    task automatic add_op(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] val);
        stim_t s;
        s.is_cap  = 1'b0;
        s.command = cmd;
        s.value   = val;
        s.bursty  = fill_bursty;
        pending.push_back(s);
    endtask

    task automatic add_capacity(logic [CAP_W-1:0] cap);
        stim_t s;
        s.is_cap  = 1'b1;
        s.command = CMD_QUERY;
        s.value   = DATA_W'(cap);
        s.bursty  = fill_bursty;
        pending.push_back(s);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return EMPTY_VALUE;
            3:       return '0;
            4:       return $urandom_range(0, 15);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(int unsigned push_weight);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < push_weight)
            return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        else if (r < 93)
            return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
        else if (r < 97)
            return CMD_QUERY;
        else
            return CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    endfunction

    initial
    begin
        int unsigned      push_weight;
        int unsigned      n_items;
        logic [CAP_W-1:0] cap;

        // directed: empty queue at reset capacity
        add_op(CMD_QUERY, '0);
        add_op(CMD_POP_FRONT, '0);
        add_op(CMD_POP_BACK, '0);
        add_op(CMD_PUSH_BACK, 32'h7FFF_FFFF);
        add_op(CMD_PUSH_FRONT, 32'h8000_0000);
        add_op(CMD_PUSH_FRONT, EMPTY_VALUE);
        add_op(CMD_POP_FRONT, '0);
        add_op(CMD_POP_FRONT, '0);
        add_op(CMD_POP_BACK, '0);
        add_op(CMD_PUSH_FRONT, 32'h1234_5678);
        add_op(CMD_SPARE_FIRST, 32'hA5A5_A5A5);
        add_op(CMD_SPARE_MID, 32'h5A5A_5A5A);
        add_op(CMD_SPARE_LAST, '0);
        // one slot, already occupied
        add_capacity(5'd1);
        add_op(CMD_QUERY, '0);
        add_op(CMD_PUSH_BACK, 32'h0000_0001);
        add_op(CMD_POP_FRONT, '0);
        add_op(CMD_PUSH_FRONT, 32'hFFFF_FFFE);
        // zero capacity: full and empty at once
        add_capacity(5'd0);
        add_op(CMD_POP_BACK, '0);
        add_op(CMD_PUSH_FRONT, 32'h0000_00FF);
        add_op(CMD_POP_FRONT, '0);
        // capacity dropped below the count held
        add_capacity(5'd16);
        add_op(CMD_PUSH_BACK, 32'h0000_0011);
        add_op(CMD_PUSH_BACK, 32'h0000_0022);
        add_op(CMD_PUSH_FRONT, 32'h0000_0033);
        add_capacity(5'd2);
        add_op(CMD_PUSH_BACK, 32'h0000_0044);
        add_op(CMD_POP_FRONT, '0);
        add_op(CMD_PUSH_FRONT, 32'h0000_0055);
        add_op(CMD_POP_BACK, '0);
        add_op(CMD_PUSH_BACK, 32'h0000_0066);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            fill_bursty = (p % 3 != 2) && (p < RANDOM_PHASES - 2);
            case (p)
                0:       cap = 5'd31;
                1:       cap = 5'd1;
                2:       cap = 5'd0;
                3:       cap = 5'd16;
                default: cap = ($urandom_range(0, 5) == 0) ? CAP_W'($urandom_range(17, 31))
                                                           : CAP_W'($urandom_range(1, 16));
            endcase
            add_capacity(cap);
            case (p % 4)
                0:       push_weight = 70;
                1:       push_weight = 25;
                2:       push_weight = 48;
                default: push_weight = 55;
            endcase
            n_items = (p == 2) ? 40 : 100;
            for (int i = 0; i < n_items; i++)
                add_op(pick_command(push_weight), pick_value());
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do
            @(negedge clk);
        while (pending.size() != 0 || req_valid_q || cfg_valid_q || expected.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("%0d operations checked, %0d refused, over %0d capacity writes",
                 results, refusals, cap_writes);
        $display("results reporting full: %0d, reporting empty: %0d", full_seen, empty_seen);
        if (mismatches == 0 && expected.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
